// ----- rtl/binary_trie_max_xor_macros.svh -----
// Assertion macros shared by the binary trie maximum XOR block.
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BXM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BXM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bxm_pkg.sv -----
// Shared types and constants for the binary trie maximum XOR block.
package bxm_pkg;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] key;
    } req_item_t;

    typedef struct packed {
        logic [31:0] best_xor;
        logic        status;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic set_full;
        logic start;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic full_insert;
        logic last_level;
    } dp_sts_t;

endpackage

// ----- rtl/bxm_stream_if.sv -----
// Valid/ready channel that carries one item per handshake.
interface bxm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/binary_trie_max_xor.sv -----
// Top level of the binary trie maximum XOR block.
// The req channel takes one item per handshake: action 0 inserts key into the
// trie, action 1 asks for the largest key XOR any stored key. Only the low
// KEY_BITS bits of key are used. The rsp channel returns exactly one item per
// request: best_xor for a query (0 for an insert or an empty trie) and status,
// which is 1 when an insert is refused because fewer than KEY_BITS nodes are free.
// An item is accepted in the idle state, then a set-up state and the walk state follow,
// with one dependent child pointer memory read per key bit; a refused insert skips
// the walk and goes from set-up straight to the result. Items are handled one at a
// time: req takes no new item until the result of the last one has been taken.
// After reset both child memories are swept to zero, one entry per cycle, over all
// NODE_COUNT entries (4096 by default); req stays not ready meanwhile.
// A result holds on rsp until it is taken; req is not ready while it waits.
module binary_trie_max_xor #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input logic          clk,
    input logic          rst_n,
    bxm_stream_if.sink   req,
    bxm_stream_if.source rsp
);

    bxm_pkg::dp_cmd_t   cmd;
    bxm_pkg::dp_sts_t   sts;
    bxm_pkg::req_item_t req_item;
    bxm_pkg::rsp_item_t rsp_item;
    logic [31:0]        rsp_best_xor;
    logic               rsp_status;

    assign req_item = req.data;
    assign rsp_item = '{best_xor: rsp_best_xor, status: rsp_status};
    assign rsp.data = rsp_item;

    bxm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bxm_datapath #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_action (req_item.action),
        .req_key    (req_item.key),
        .best_xor   (rsp_best_xor),
        .status     (rsp_status)
    );

endmodule

// ----- rtl/bxm_ctrl.sv -----
// Controller state machine that sequences clearing, trie walks and result handoff.
`include "binary_trie_max_xor_macros.svh"

module bxm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output bxm_pkg::dp_cmd_t cmd,
    input  bxm_pkg::dp_sts_t sts
);

    bxm_pkg::state_t state_reg;
    bxm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bxm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            bxm_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = bxm_pkg::ST_IDLE;
                end
            end
            bxm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bxm_pkg::ST_START;
                end
            end
            bxm_pkg::ST_START:
            begin
                if (sts.full_insert)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = bxm_pkg::ST_DONE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = bxm_pkg::ST_WALK;
                end
            end
            bxm_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (sts.last_level)
                begin
                    state_next = bxm_pkg::ST_DONE;
                end
            end
            bxm_pkg::ST_DONE:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = bxm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bxm_pkg::ST_CLEAR;
            end
        endcase
    end

    `BXM_ASSERT_NEXT(a_full_skips_walk, (state_reg == bxm_pkg::ST_START) && sts.full_insert,
        state_reg == bxm_pkg::ST_DONE, "rejected insert did not go straight to the result")
    `BXM_ASSERT_NEXT(a_walk_runs_on, (state_reg == bxm_pkg::ST_WALK) && !sts.last_level,
        state_reg == bxm_pkg::ST_WALK, "trie walk ended before the last level")
    `BXM_ASSERT_NEXT(a_result_taken, rsp_valid && rsp_ready,
        state_reg == bxm_pkg::ST_IDLE, "controller did not return to idle after handoff")

endmodule

// ----- rtl/bxm_datapath.sv -----
// Datapath with the child pointer memories, walk registers and result registers.
`include "binary_trie_max_xor_macros.svh"

module bxm_datapath #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bxm_pkg::dp_cmd_t cmd,
    output bxm_pkg::dp_sts_t sts,
    input  logic             req_action,
    input  logic [31:0]      req_key,
    output logic [31:0]      best_xor,
    output logic             status
);

    localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W   = $clog2(NODE_COUNT + 1);
    localparam int LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int FULL_AT = NODE_COUNT - KEY_BITS;

    logic [NODE_W-1:0]   child_zero_mem [NODE_COUNT];
    logic [NODE_W-1:0]   child_one_mem  [NODE_COUNT];
    logic [NODE_W-1:0]   rd0_reg;
    logic [NODE_W-1:0]   rd1_reg;

    logic [NODE_W-1:0]   node_reg;
    logic [NODE_W-1:0]   node_next;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LVL_W-1:0]    lvl_next;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;
    logic [CNT_W-1:0]    clr_reg;
    logic [CNT_W-1:0]    clr_next;
    logic                action_reg;
    logic                action_next;
    logic [KEY_BITS-1:0] key_sh_reg;
    logic [KEY_BITS-1:0] key_sh_next;
    logic [KEY_BITS-1:0] best_reg;
    logic [KEY_BITS-1:0] best_next;
    logic                status_reg;
    logic                status_next;

    logic [NODE_W-1:0]   rd_addr;
    logic [NODE_W-1:0]   wr_addr;
    logic [NODE_W-1:0]   wr_data;
    logic                we0;
    logic                we1;
    logic                alloc;
    logic                key_bit;
    logic [NODE_W-1:0]   child_same;
    logic [NODE_W-1:0]   child_opp;
    logic [NODE_W-1:0]   walk_node;

    always_comb
    begin
        node_next   = node_reg;
        lvl_next    = lvl_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        action_next = action_reg;
        key_sh_next = key_sh_reg;
        best_next   = best_reg;
        status_next = status_reg;
        rd_addr     = '0;
        wr_addr     = node_reg;
        wr_data     = used_reg[NODE_W-1:0];
        we0         = 1'b0;
        we1         = 1'b0;
        alloc       = 1'b0;
        walk_node   = '0;
        key_bit     = key_sh_reg[KEY_BITS-1];
        child_same  = key_bit ? rd1_reg : rd0_reg;
        child_opp   = key_bit ? rd0_reg : rd1_reg;

        if (cmd.clr)
        begin
            we0      = 1'b1;
            we1      = 1'b1;
            wr_addr  = clr_reg[NODE_W-1:0];
            wr_data  = '0;
            clr_next = clr_reg + 1'b1;
        end
        if (cmd.load)
        begin
            action_next = req_action;
            key_sh_next = KEY_BITS'(req_key);
            best_next   = '0;
            status_next = bxm_pkg::STATUS_OK;
        end
        if (cmd.set_full)
        begin
            status_next = bxm_pkg::STATUS_FULL;
        end
        if (cmd.start)
        begin
            rd_addr   = '0;
            node_next = '0;
            lvl_next  = LVL_W'(KEY_BITS - 1);
        end
        if (cmd.step)
        begin
            if (action_reg == bxm_pkg::ACT_INSERT)
            begin
                if (child_same == '0)
                begin
                    alloc     = 1'b1;
                    we0       = !key_bit;
                    we1       = key_bit;
                    wr_addr   = node_reg;
                    wr_data   = used_reg[NODE_W-1:0];
                    walk_node = used_reg[NODE_W-1:0];
                    used_next = used_reg + 1'b1;
                end
                else
                begin
                    walk_node = child_same;
                end
            end
            else if (child_opp != '0)
            begin
                walk_node = child_opp;
                best_next = (best_reg << 1) | KEY_BITS'(1);
            end
            else
            begin
                walk_node = child_same;
                best_next = best_reg << 1;
            end
            rd_addr     = walk_node;
            node_next   = walk_node;
            lvl_next    = lvl_reg - 1'b1;
            key_sh_next = key_sh_reg << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            child_zero_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= child_zero_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            child_one_mem[wr_addr] <= wr_data;
        end
        rd1_reg <= child_one_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= CNT_W'(1);
            clr_reg  <= '0;
            lvl_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            clr_reg  <= clr_next;
            lvl_reg  <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        action_reg <= action_next;
        key_sh_reg <= key_sh_next;
        best_reg   <= best_next;
        status_reg <= status_next;
    end

    assign sts.clr_last    = (clr_reg == CNT_W'(NODE_COUNT - 1));
    assign sts.full_insert = (action_reg == bxm_pkg::ACT_INSERT) &&
                             (used_reg > CNT_W'(FULL_AT));
    assign sts.last_level  = (lvl_reg == '0);
    assign best_xor        = 32'(best_reg);
    assign status          = status_reg;

    `BXM_ASSERT_SAME(a_pool_bound, 1'b1, used_reg <= CNT_W'(NODE_COUNT),
        "node count exceeds the pool")
    `BXM_ASSERT_SAME(a_alloc_insert_only, alloc, action_reg == bxm_pkg::ACT_INSERT,
        "node allocated during a query")
    `BXM_ASSERT_NEXT(a_alloc_counts, alloc, used_reg == $past(used_reg) + 1'b1,
        "allocation did not advance the node count by one")

endmodule

// ----- tb/sv/binary_trie_max_xor_tb.sv -----
// Self-checking testbench for the binary trie maximum XOR block, checked against a trie predictor.
module binary_trie_max_xor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BITS     = 32;
    localparam int NODE_COUNT   = 4096;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 4;
    localparam int DIR_ROWS     = 23;
    localparam bit PREDICTED    = 1'b0;
    localparam bit TYPED        = 1'b1;

    typedef struct packed {
        logic               fixed_rsp;
        bxm_pkg::req_item_t item;
        bxm_pkg::rsp_item_t want;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        {TYPED,     bxm_pkg::ACT_QUERY,  32'h0000_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'h0000_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_QUERY,  32'h8000_0000, 32'h8000_0000, bxm_pkg::STATUS_OK},
        {TYPED,     bxm_pkg::ACT_INSERT, 32'h8000_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_INSERT, 32'h0000_0001, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'h0000_0001, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'h7FFF_FFFE, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_INSERT, 32'hAAAA_AAAA, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'h5555_5555, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'hAAAA_AAAA, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_INSERT, 32'h1234_5678, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'hEDCB_A987, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'h0001_0000, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_INSERT, 32'hFFFF_FFFE, 32'h0000_0000, bxm_pkg::STATUS_OK},
        {PREDICTED, bxm_pkg::ACT_QUERY,  32'h0000_0001, 32'h0000_0000, bxm_pkg::STATUS_OK}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bxm_stream_if #(.T(bxm_pkg::req_item_t)) req_ch ();
    bxm_stream_if #(.T(bxm_pkg::rsp_item_t)) rsp_ch ();

    binary_trie_max_xor #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bit [11:0]          trie_zero [NODE_COUNT];
    bit [11:0]          trie_one  [NODE_COUNT];
    int                 pool_used = 1;
    bit [31:0]          stored_keys [$];
    bit [21:0]          cluster_prefix [8];
    bxm_pkg::rsp_item_t pending_rsp [$];
    int                 fail_count = 0;
    int                 send_idle_pct = 0;
    int                 sink_stall_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bxm_pkg::rsp_item_t trie_step(input bxm_pkg::req_item_t item);
        bxm_pkg::rsp_item_t res;
        int                 node;
        bit [11:0]          nxt;
        logic               bit_val;
        res  = '0;
        node = 0;
        if (item.action == bxm_pkg::ACT_INSERT)
        begin
            if (NODE_COUNT - pool_used < KEY_BITS)
            begin
                res.status = bxm_pkg::STATUS_FULL;
            end
            else
            begin
                res.status = bxm_pkg::STATUS_OK;
                for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--)
                begin
                    bit_val = item.key[lvl];
                    nxt = bit_val ? trie_one[node] : trie_zero[node];
                    if (nxt == 0)
                    begin
                        nxt = 12'(pool_used);
                        pool_used++;
                        trie_zero[nxt] = '0;
                        trie_one[nxt]  = '0;
                        if (bit_val)
                            trie_one[node] = nxt;
                        else
                            trie_zero[node] = nxt;
                    end
                    node = nxt;
                end
                stored_keys = {stored_keys, item.key};
            end
        end
        else if (pool_used > 1)
        begin
            for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--)
            begin
                bit_val = item.key[lvl];
                nxt = bit_val ? trie_zero[node] : trie_one[node];
                if (nxt != 0)
                begin
                    res.best_xor[lvl] = 1'b1;
                    node = nxt;
                end
                else
                begin
                    node = bit_val ? trie_one[node] : trie_zero[node];
                end
            end
        end
        return res;
    endfunction

    function automatic bit [31:0] pick_key();
        bit [31:0] known;
        bit [31:0] one_hot;
        one_hot = 32'h1 << $urandom_range(31);
        known   = (stored_keys.size() != 0) ?
                  stored_keys[$urandom_range(stored_keys.size() - 1)] : $urandom;
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5: return {cluster_prefix[$urandom_range(7)], 10'($urandom)};
            6:       return known;
            7:       return known ^ one_hot ^ ($urandom_range(1) ? 32'h0 : 32'($urandom_range(15)));
            8:       return ~known;
            default:
            begin
                case ($urandom_range(3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return one_hot;
                    default: return ~one_hot;
                endcase
            end
        endcase
    endfunction

    function automatic bxm_pkg::req_item_t pick_item();
        bxm_pkg::req_item_t item;
        item.action = ($urandom_range(99) < 45) ? bxm_pkg::ACT_INSERT : bxm_pkg::ACT_QUERY;
        item.key    = pick_key();
        return item;
    endfunction

    task automatic drive_item(input bxm_pkg::req_item_t item, input bit fixed_rsp,
                              input bxm_pkg::rsp_item_t want);
        bxm_pkg::rsp_item_t model_rsp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        model_rsp = trie_step(item);
        if (fixed_rsp)
            model_rsp = want;
        pending_rsp = {pending_rsp, model_rsp};
    endtask

    task automatic check_rsp(input bxm_pkg::rsp_item_t got);
        bxm_pkg::rsp_item_t want;
        if (pending_rsp.size() == 0)
        begin
            $display("%0t: unexpected item best_xor=%h status=%0d", $time, got.best_xor,
                     got.status);
            fail_count++;
        end
        else
        begin
            want = pending_rsp.pop_front();
            if (got.best_xor !== want.best_xor)
            begin
                $display("%0t: best_xor expected %h actual %h", $time, want.best_xor,
                         got.best_xor);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_rsp(rsp_ch.data);
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        foreach (cluster_prefix[i])
            cluster_prefix[i] = 22'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < DIR_ROWS; row++)
            drive_item(DIR_TABLE[row].item, DIR_TABLE[row].fixed_rsp, DIR_TABLE[row].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_idle_pct = 67; sink_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin send_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                drive_item(pick_item(), PREDICTED, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (KEY_BITS + 8) @(posedge clk);

        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("binary_trie_max_xor test passed");
        else
            $display("binary_trie_max_xor test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("binary_trie_max_xor test failed");
        $finish;
    end

endmodule
